FILE: sv/assert_macros.svh
// Assertion helper macros shared by the deframer RTL.
// Assertions are clocked on clk_i and masked while rst_ni is low.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: sv/wsdf_pkg.sv
// Types and constants for the WebSocket frame deframer.
// Standalone package; used by websocket_frame_deframer.
package wsdf_pkg;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXTLEN  = 6'b000100,
    PH_MASKKEY = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_STOPPED = 6'b100000
  } phase_e;

  // Frame opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_EMPTY_END = 2'd1;
  localparam logic [1:0] KIND_CLOSE     = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  // Length codes in the second header byte
  localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN_CODE16   = 7'd126;
  localparam logic [6:0] LEN_CODE64   = 7'd127;

  // Remaining header bytes after the first one of each extension
  localparam logic [2:0] EXT16_LEFT = 3'd1;
  localparam logic [2:0] EXT64_LEFT = 3'd7;
  localparam logic [2:0] MASK_LEFT  = 3'd3;

  localparam int unsigned LEN_W = 64;

endpackage

FILE: sv/websocket_frame_deframer.sv
// WebSocket receive deframer: one byte per request, zero or one result per byte.
// A result is registered and appears on the outputs in the cycle after its byte is taken.
// Throughput: one byte per cycle; the only back-pressure is a full result
// register whose request is being stalled downstream.
// Reset (rst_ni low, asynchronous): parser back to the first header byte,
// message type binary, result register empty. Depends on wsdf_pkg, assert_macros.svh.
`include "assert_macros.svh"

module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte stream in
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // results out
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic       message_is_binary_o,
  output logic       message_end_o
);

  localparam int unsigned LW = wsdf_pkg::LEN_W;

  // Parser state
  wsdf_pkg::phase_e phase_q, phase_d;
  logic             final_q, final_d;     // FIN of current frame
  logic [3:0]       op_q, op_d;           // opcode of current frame
  logic             masked_q, masked_d;   // mask bit of current frame
  logic [2:0]       hbc_q, hbc_d;         // header bytes still to come
  logic [LW-1:0]    rem_q, rem_d;         // payload bytes still to come
  logic             bin_q, bin_d;         // current message type

  // Result register
  logic       out_valid_q, out_valid_d;
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic       mbin_q;
  logic       mend_q;

  // Combinational result of this byte
  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_data;
  logic       res_bin;
  logic       res_end;

  logic          in_acc;
  logic          out_load;
  logic          data_op;
  logic          hdr_done;   // length (and any mask key) is complete
  logic          masked_hd;  // mask bit seen by the header completion step
  logic [LW-1:0] rem_hd;     // length seen by the header completion step
  logic [LW-1:0] rem_ext;
  logic [LW-1:0] rem_dec;
  logic [3:0]    rx_op;
  logic          rx_ctrl;
  logic          rx_known;
  logic [6:0]    rx_len;

  // A byte may come in unless the result register is full and held.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_load   = ~out_valid_q | ~out_stall_i;

  assign data_op = (op_q == wsdf_pkg::OP_CONT) || (op_q == wsdf_pkg::OP_TEXT) ||
                   (op_q == wsdf_pkg::OP_BIN);

  assign rx_op    = rx_byte_i[3:0];
  assign rx_ctrl  = (rx_op == wsdf_pkg::OP_CLOSE) || (rx_op == wsdf_pkg::OP_PING);
  assign rx_known = rx_ctrl || (rx_op == wsdf_pkg::OP_CONT) || (rx_op == wsdf_pkg::OP_TEXT) ||
                    (rx_op == wsdf_pkg::OP_BIN) || (rx_op == wsdf_pkg::OP_PONG);
  assign rx_len   = rx_byte_i[6:0];

  // Extended length is big-endian: shift in one byte at a time.
  assign rem_ext = {rem_q[LW-9:0], rx_byte_i};
  assign rem_dec = rem_q - LW'(1);

  always_comb begin
    phase_d   = phase_q;
    final_d   = final_q;
    op_d      = op_q;
    masked_d  = masked_q;
    hbc_d     = hbc_q;
    rem_d     = rem_q;
    bin_d     = bin_q;
    res_valid = 1'b0;
    res_kind  = wsdf_pkg::KIND_PAYLOAD;
    res_data  = 8'd0;
    res_bin   = 1'b0;
    res_end   = 1'b0;
    hdr_done  = 1'b0;
    masked_hd = masked_q;
    rem_hd    = rem_q;

    if (in_acc) begin
      unique case (phase_q)
        wsdf_pkg::PH_HDR0: begin
          final_d = rx_byte_i[7];
          op_d    = rx_op;
          // RSV bits are tolerated on pong only
          if (((rx_byte_i[6:4] != 3'd0) && (rx_op != wsdf_pkg::OP_PONG)) || !rx_known ||
              (rx_ctrl && !rx_byte_i[7])) begin
            phase_d   = wsdf_pkg::PH_STOPPED;
            res_valid = 1'b1;
            res_kind  = wsdf_pkg::KIND_ERROR;
          end else begin
            if (rx_op == wsdf_pkg::OP_TEXT) begin
              bin_d = 1'b0;
            end else if (rx_op == wsdf_pkg::OP_BIN) begin
              bin_d = 1'b1;
            end
            phase_d = wsdf_pkg::PH_HDR1;
          end
        end
        wsdf_pkg::PH_HDR1: begin
          masked_d = rx_byte_i[7];
          if (rx_byte_i[7] && (op_q != wsdf_pkg::OP_PONG)) begin
            phase_d   = wsdf_pkg::PH_STOPPED;
            res_valid = 1'b1;
            res_kind  = wsdf_pkg::KIND_ERROR;
          end else if (op_q == wsdf_pkg::OP_CLOSE) begin
            // close payload is never read
            phase_d   = wsdf_pkg::PH_STOPPED;
            res_valid = 1'b1;
            res_kind  = wsdf_pkg::KIND_CLOSE;
          end else if ((op_q == wsdf_pkg::OP_PING) && (rx_len > wsdf_pkg::LEN_CTRL_MAX)) begin
            phase_d   = wsdf_pkg::PH_STOPPED;
            res_valid = 1'b1;
            res_kind  = wsdf_pkg::KIND_ERROR;
          end else if (rx_len == wsdf_pkg::LEN_CODE16) begin
            rem_d   = '0;
            hbc_d   = wsdf_pkg::EXT16_LEFT;
            phase_d = wsdf_pkg::PH_EXTLEN;
          end else if (rx_len == wsdf_pkg::LEN_CODE64) begin
            rem_d   = '0;
            hbc_d   = wsdf_pkg::EXT64_LEFT;
            phase_d = wsdf_pkg::PH_EXTLEN;
          end else begin
            rem_d     = {{(LW-7){1'b0}}, rx_len};
            rem_hd    = {{(LW-7){1'b0}}, rx_len};
            masked_hd = rx_byte_i[7];
            hdr_done  = 1'b1;
          end
        end
        wsdf_pkg::PH_EXTLEN: begin
          rem_d = rem_ext;
          if (hbc_q != 3'd0) begin
            hbc_d = hbc_q - 3'd1;
          end else begin
            rem_hd   = rem_ext;
            hdr_done = 1'b1;
          end
        end
        wsdf_pkg::PH_MASKKEY: begin
          if (hbc_q != 3'd0) begin
            hbc_d = hbc_q - 3'd1;
          end else begin
            hdr_done = 1'b1;
          end
        end
        wsdf_pkg::PH_PAYLOAD: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = wsdf_pkg::PH_HDR0;
          end
          // ping and pong payloads are swallowed
          if (data_op) begin
            res_valid = 1'b1;
            res_kind  = wsdf_pkg::KIND_PAYLOAD;
            res_data  = rx_byte_i;
            res_bin   = bin_q;
            res_end   = final_q && (rem_dec == '0);
          end
        end
        wsdf_pkg::PH_STOPPED: begin
          // dead until reset
        end
        default: begin
          phase_d = wsdf_pkg::PH_STOPPED;
        end
      endcase

      // Header complete: masked pong first skips its key, then payload or frame end.
      if (hdr_done) begin
        if (masked_hd && (op_q == wsdf_pkg::OP_PONG) && (phase_q != wsdf_pkg::PH_MASKKEY)) begin
          phase_d = wsdf_pkg::PH_MASKKEY;
          hbc_d   = wsdf_pkg::MASK_LEFT;
        end else if (rem_hd == '0) begin
          phase_d = wsdf_pkg::PH_HDR0;
          if (data_op && final_q) begin
            res_valid = 1'b1;
            res_kind  = wsdf_pkg::KIND_EMPTY_END;
            res_bin   = bin_q;
            res_end   = 1'b1;
          end
        end else begin
          phase_d = wsdf_pkg::PH_PAYLOAD;
        end
      end
    end
  end

  assign out_valid_d = out_load ? (in_acc & res_valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsdf_pkg::PH_HDR0;
      final_q     <= 1'b0;
      op_q        <= wsdf_pkg::OP_CONT;
      masked_q    <= 1'b0;
      hbc_q       <= 3'd0;
      rem_q       <= '0;
      bin_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      final_q     <= final_d;
      op_q        <= op_d;
      masked_q    <= masked_d;
      hbc_q       <= hbc_d;
      rem_q       <= rem_d;
      bin_q       <= bin_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_load && in_acc && res_valid) begin
      kind_q <= res_kind;
      data_q <= res_data;
      mbin_q <= res_bin;
      mend_q <= res_end;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign kind_o              = kind_q;
  assign data_byte_o         = data_q;
  assign message_is_binary_o = mbin_q;
  assign message_end_o       = mend_q;

  // Checks
  logic stopped;
  logic in_payload;
  logic term_res;   // close or error leaving this cycle

  assign stopped    = (phase_q == wsdf_pkg::PH_STOPPED);
  assign in_payload = (phase_q == wsdf_pkg::PH_PAYLOAD);
  assign term_res   = res_valid &&
                      ((res_kind == wsdf_pkg::KIND_CLOSE) || (res_kind == wsdf_pkg::KIND_ERROR));

  `ASSERT_HOLDS(a_stopped_sticks, stopped |=> stopped, "parser left stopped state")
  `ASSERT_HOLDS(a_stopped_silent, (in_acc && stopped) |=> !out_valid_o, "result after stop")
  `ASSERT_HOLDS(a_term_stops, (in_acc && term_res) |=> stopped, "close or error did not stop")
  `ASSERT_NEVER(a_payload_nonzero, in_payload && (rem_q == '0), "payload phase, nothing left")

endmodule
